### rtl/core/htl_pkg.sv
// Shared types, constants and the arctangent table of the helix tube level datapath.
`timescale 1ns / 1ps

package htl_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int ANG_FRAC      = 28;
	localparam int DIV_STEPS     = 62;
	localparam int ROOT_STEPS    = 32;

	localparam logic signed [31:0] PI_HALF_Q = 32'sd421657428;
	localparam logic [30:0]        TWO_PI_Q  = 31'd1686629713;

	localparam logic signed [63:0] LEVEL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] LEVEL_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		CFG_HELIX_RADIUS    = 2'd0,
		CFG_HELIX_PITCH     = 2'd1,
		CFG_TUBE_RADIUS     = 2'd2,
		CFG_INSIDE_NEGATIVE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [63:0] level_value;
		logic               saturated;
	} level_t;

	// Register file as seen by the datapath, with the derived products
	typedef struct packed {
		logic [30:0] helix_radius;
		logic [30:0] helix_pitch;
		logic [61:0] turn_len;
		logic [61:0] tube_r2;
		logic        inside_negative;
	} cfg_t;

	// atan(2^-i) in Q.28 radians
	function automatic logic signed [31:0] atan_q(input int i);
		logic signed [31:0] v;
		case (i)
			0:  v = 32'sd210828714;
			1:  v = 32'sd124459457;
			2:  v = 32'sd65760959;
			3:  v = 32'sd33381290;
			4:  v = 32'sd16755422;
			5:  v = 32'sd8385879;
			6:  v = 32'sd4193963;
			7:  v = 32'sd2097109;
			8:  v = 32'sd1048571;
			9:  v = 32'sd524287;
			10: v = 32'sd262144;
			11: v = 32'sd131072;
			12: v = 32'sd65536;
			13: v = 32'sd32768;
			14: v = 32'sd16384;
			15: v = 32'sd8192;
			16: v = 32'sd4096;
			17: v = 32'sd2048;
			18: v = 32'sd1024;
			19: v = 32'sd512;
			20: v = 32'sd256;
			21: v = 32'sd128;
			22: v = 32'sd64;
			23: v = 32'sd32;
			24: v = 32'sd16;
			25: v = 32'sd8;
			26: v = 32'sd4;
			27: v = 32'sd2;
			28: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/helix_tube_level_value.sv
// Top level of the helix tube level value datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  in       | in_valid / in_stall    | in_data   (point_x, point_y, point_z)
//  out      | out_valid / out_stall  | out_data  (level_value, saturated)
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One point is taken every cycle unless a held result stalls the pipeline; each result passes through
// the 24 CORDIC stages, the 62-stage restoring remainder and the 32-stage square root.
// arst_n clears every valid bit and loads the register reset values.
// A transfer held on out stalls the whole pipeline, and in_stall rises with it.
// The turn length and squared tube radius are registered and follow a register write in the next cycle.
`timescale 1ns / 1ps

module helix_tube_level_value (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  htl_pkg::point_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output htl_pkg::level_t   out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  htl_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]       cfg_data
);
	import htl_pkg::*;

	logic [30:0] helix_radius_q, helix_pitch_q, tube_radius_q;
	logic        inside_negative_q;
	logic [61:0] turn_len_q, tube_r2_q;
	cfg_t        cfg;

	logic   en;
	logic   v_s1;
	point_t pt_s1;

	logic               cor_valid;
	logic signed [31:0] cor_angle;
	point_t             cor_point;
	logic               mod_valid, mod_big;
	logic [31:0]        mod_dzf;
	point_t             mod_point;
	logic               sq_valid, sq_big;
	logic [31:0]        sq_rho, sq_dzf;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			helix_radius_q    <= 31'd65536;
			helix_pitch_q     <= 31'd65536;
			tube_radius_q     <= 31'd16384;
			inside_negative_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HELIX_RADIUS:    helix_radius_q    <= cfg_data[30:0];
				CFG_HELIX_PITCH:     helix_pitch_q     <= cfg_data[30:0];
				CFG_TUBE_RADIUS:     tube_radius_q     <= cfg_data[30:0];
				CFG_INSIDE_NEGATIVE: inside_negative_q <= cfg_data[0];
				default:             inside_negative_q <= inside_negative_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		turn_len_q <= helix_pitch_q * TWO_PI_Q;
		tube_r2_q  <= tube_radius_q * tube_radius_q;
	end

	always_comb begin
		cfg.helix_radius    = helix_radius_q;
		cfg.helix_pitch     = helix_pitch_q;
		cfg.turn_len        = turn_len_q;
		cfg.tube_r2         = tube_r2_q;
		cfg.inside_negative = inside_negative_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	htl_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_point  (pt_s1),
		.out_valid (cor_valid),
		.angle     (cor_angle),
		.out_point (cor_point)
	);

	htl_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (cor_valid),
		.angle     (cor_angle),
		.in_point  (cor_point),
		.out_valid (mod_valid),
		.dz_big    (mod_big),
		.dz_frac   (mod_dzf),
		.out_point (mod_point)
	);

	htl_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (mod_valid),
		.in_point   (mod_point),
		.in_dz_big  (mod_big),
		.in_dz_frac (mod_dzf),
		.out_valid  (sq_valid),
		.rho        (sq_rho),
		.dz_big     (sq_big),
		.dz_frac    (sq_dzf)
	);

	htl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (sq_valid),
		.rho       (sq_rho),
		.dz_big    (sq_big),
		.dz_frac   (sq_dzf),
		.out_valid (out_valid),
		.out_level (out_data)
	);

endmodule

### rtl/core/htl_cordic.sv
// Pipelined vectoring CORDIC that yields the polar angle of (x, y) in Q.28 radians.
`timescale 1ns / 1ps

module htl_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  htl_pkg::point_t    in_point,
	output logic               out_valid,
	output logic signed [31:0] angle,
	output htl_pkg::point_t    out_point
);
	import htl_pkg::*;

	logic signed [63:0] x_s    [0:CORDIC_STAGES];
	logic signed [63:0] y_s    [0:CORDIC_STAGES];
	logic signed [31:0] a_s    [0:CORDIC_STAGES];
	logic               zero_s [0:CORDIC_STAGES];
	point_t             pt_s   [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0] v_s;

	logic signed [63:0] xw, yw, x0, y0;
	logic signed [31:0] a0;

	// fold the left half plane into the right one
	always_comb begin
		xw = $signed({{4{in_point.point_x[31]}}, in_point.point_x, 28'd0});
		yw = $signed({{4{in_point.point_y[31]}}, in_point.point_y, 28'd0});
		x0 = xw;
		y0 = yw;
		a0 = '0;
		if (xw[63]) begin
			if (!yw[63]) begin
				x0 = yw;
				y0 = -xw;
				a0 = PI_HALF_Q;
			end else begin
				x0 = -yw;
				y0 = xw;
				a0 = -PI_HALF_Q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x0;
			y_s[0]    <= y0;
			a_s[0]    <= a0;
			zero_s[0] <= (in_point.point_x == '0) && (in_point.point_y == '0);
			pt_s[0]   <= in_point;
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				if (!y_s[i][63]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_q(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_q(i);
				end
				zero_s[i+1] <= zero_s[i];
				pt_s[i+1]   <= pt_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[CORDIC_STAGES-1:0], in_valid};
		end
	end

	assign out_valid = v_s[CORDIC_STAGES];
	assign angle     = zero_s[CORDIC_STAGES] ? 32'sd0 : a_s[CORDIC_STAGES];
	assign out_point = pt_s[CORDIC_STAGES];

endmodule

### rtl/core/htl_mod.sv
// Axial gap to the nearest helix turn: w = z - pitch*theta reduced modulo one turn length.
`timescale 1ns / 1ps

module htl_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  htl_pkg::cfg_t      cfg,
	input  logic               in_valid,
	input  logic signed [31:0] angle,
	input  htl_pkg::point_t    in_point,
	output logic               out_valid,
	output logic               dz_big,
	output logic [31:0]        dz_frac,
	output htl_pkg::point_t    out_point
);
	import htl_pkg::*;

	logic signed [63:0] prod_s1;
	point_t             pt_s1;
	logic signed [63:0] w_s2;
	point_t             pt_s2;

	logic [61:0] rem_d [0:DIV_STEPS];
	logic [61:0] wa_d  [0:DIV_STEPS];
	point_t      pt_d  [0:DIV_STEPS];

	logic [61:0] dz_f1;
	point_t      pt_f1;
	logic        big_f2;
	logic [31:0] dzf_f2;
	point_t      pt_f2;

	logic [DIV_STEPS+4:0] v_s;

	logic signed [31:0] pitch_s;
	logic signed [63:0] zw;
	logic [61:0]        len_m_rem;
	logic [62:0]        dz_rnd;

	assign pitch_s   = $signed({1'b0, cfg.helix_pitch});
	assign zw        = $signed({{4{pt_s1.point_z[31]}}, pt_s1.point_z, 28'd0});
	assign len_m_rem = cfg.turn_len - rem_d[DIV_STEPS];
	assign dz_rnd    = {1'b0, dz_f1} + 63'(64'd1 << (ANG_FRAC - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= pitch_s * angle;
			pt_s1   <= in_point;
			w_s2    <= zw - prod_s1;
			pt_s2   <= pt_s1;
			rem_d[0] <= '0;
			wa_d[0]  <= w_s2[63] ? 62'(-w_s2) : w_s2[61:0];
			pt_d[0]  <= pt_s2;
			// restoring remainder, one dividend bit a stage; a zero length leaves |w|
			for (int k = 0; k < DIV_STEPS; k++) begin
				if ({rem_d[k], wa_d[k][DIV_STEPS-1-k]} >= {1'b0, cfg.turn_len}) begin
					rem_d[k+1] <= 62'({rem_d[k], wa_d[k][DIV_STEPS-1-k]} -
						{1'b0, cfg.turn_len});
				end else begin
					rem_d[k+1] <= 62'({rem_d[k], wa_d[k][DIV_STEPS-1-k]});
				end
				wa_d[k+1] <= wa_d[k];
				pt_d[k+1] <= pt_d[k];
			end
			// the nearer turn is the same whichever sign w had
			if (cfg.turn_len == '0 || rem_d[DIV_STEPS] < len_m_rem) begin
				dz_f1 <= rem_d[DIV_STEPS];
			end else begin
				dz_f1 <= len_m_rem;
			end
			pt_f1  <= pt_d[DIV_STEPS];
			big_f2 <= |dz_rnd[62:ANG_FRAC+32];
			dzf_f2 <= dz_rnd[ANG_FRAC+31:ANG_FRAC];
			pt_f2  <= pt_f1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STEPS+3:0], in_valid};
		end
	end

	assign out_valid = v_s[DIV_STEPS+4];
	assign dz_big    = big_f2;
	assign dz_frac   = dzf_f2;
	assign out_point = pt_f2;

endmodule

### rtl/core/htl_sqrt.sv
// Radial distance rho = sqrt(x^2 + y^2) rounded to nearest, two radicand bits a stage.
`timescale 1ns / 1ps

module htl_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  htl_pkg::point_t in_point,
	input  logic            in_dz_big,
	input  logic [31:0]     in_dz_frac,
	output logic            out_valid,
	output logic [31:0]     rho,
	output logic            dz_big,
	output logic [31:0]     dz_frac
);
	import htl_pkg::*;

	logic [31:0] ax_s1, ay_s1;
	logic [63:0] sx_s2, sy_s2;

	logic [63:0] s_r    [0:ROOT_STEPS];
	logic [33:0] rem_r  [0:ROOT_STEPS];
	logic [31:0] root_r [0:ROOT_STEPS];

	logic        big_p  [0:ROOT_STEPS+2];
	logic [31:0] dzf_p  [0:ROOT_STEPS+2];

	logic [31:0] rho_s;
	logic        big_s;
	logic [31:0] dzf_s;

	logic [ROOT_STEPS+3:0] v_s;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= in_point.point_x[31] ? -in_point.point_x : in_point.point_x;
			ay_s1 <= in_point.point_y[31] ? -in_point.point_y : in_point.point_y;
			big_p[0] <= in_dz_big;
			dzf_p[0] <= in_dz_frac;
			sx_s2 <= ax_s1 * ax_s1;
			sy_s2 <= ay_s1 * ay_s1;
			big_p[1] <= big_p[0];
			dzf_p[1] <= dzf_p[0];
			s_r[0]    <= sx_s2 + sy_s2;
			rem_r[0]  <= '0;
			root_r[0] <= '0;
			big_p[2]  <= big_p[1];
			dzf_p[2]  <= dzf_p[1];
			for (int j = 0; j < ROOT_STEPS; j++) begin
				if ({rem_r[j], s_r[j][63-2*j -: 2]} >= {2'b00, root_r[j], 2'b01}) begin
					rem_r[j+1]  <= 34'({rem_r[j], s_r[j][63-2*j -: 2]} -
						{2'b00, root_r[j], 2'b01});
					root_r[j+1] <= {root_r[j][30:0], 1'b1};
				end else begin
					rem_r[j+1]  <= 34'({rem_r[j], s_r[j][63-2*j -: 2]});
					root_r[j+1] <= {root_r[j][30:0], 1'b0};
				end
				s_r[j+1]   <= s_r[j];
				big_p[j+3] <= big_p[j+2];
				dzf_p[j+3] <= dzf_p[j+2];
			end
			// round up when the remainder passes the root
			rho_s <= root_r[ROOT_STEPS] +
				32'(rem_r[ROOT_STEPS] > {2'b00, root_r[ROOT_STEPS]});
			big_s <= big_p[ROOT_STEPS+2];
			dzf_s <= dzf_p[ROOT_STEPS+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[ROOT_STEPS+2:0], in_valid};
		end
	end

	assign out_valid = v_s[ROOT_STEPS+3];
	assign rho       = rho_s;
	assign dz_big    = big_s;
	assign dz_frac   = dzf_s;

endmodule

### rtl/core/htl_out.sv
// Radial offset from the helix, squares, sum, tube offset, sign and clamp; the last stage is the output register.
`timescale 1ns / 1ps

module htl_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  htl_pkg::cfg_t   cfg,
	input  logic            in_valid,
	input  logic [31:0]     rho,
	input  logic            dz_big,
	input  logic [31:0]     dz_frac,
	output logic            out_valid,
	output htl_pkg::level_t out_level
);
	import htl_pkg::*;

	logic signed [32:0] dxy_s1;
	logic               big_s1;
	logic [31:0]        dzf_s1;
	logic [31:0]        adxy_s2;
	logic               big_s2;
	logic [31:0]        dzf_s2;
	logic [63:0]        dxy2_s3, dz2_s3;
	logic               big_s3;
	logic [64:0]        sum_s4;
	logic               big_s4;
	logic [63:0]        mag_s5;
	logic               neg_s5, sat_s5;
	level_t             level_s6;
	logic [5:0]         v_s;

	logic [64:0] diff;
	logic [63:0] r2w;
	logic        flip;

	assign r2w  = {2'b00, cfg.tube_r2};
	assign diff = {1'b0, sum_s4[63:0]} - {1'b0, r2w};
	assign flip = neg_s5 ^ !cfg.inside_negative;

	always_ff @(posedge clk) begin
		if (en) begin
			dxy_s1  <= $signed({1'b0, rho}) - $signed({2'b00, cfg.helix_radius});
			big_s1  <= dz_big;
			dzf_s1  <= dz_frac;
			adxy_s2 <= dxy_s1[32] ? 32'(-dxy_s1) : dxy_s1[31:0];
			big_s2  <= big_s1;
			dzf_s2  <= dzf_s1;
			dxy2_s3 <= adxy_s2 * adxy_s2;
			dz2_s3  <= dzf_s2 * dzf_s2;
			big_s3  <= big_s2;
			sum_s4  <= {1'b0, dxy2_s3} + {1'b0, dz2_s3};
			big_s4  <= big_s3;
			// below the tube radius the magnitude comes from the reverse subtraction
			mag_s5  <= diff[64] ? (r2w - sum_s4[63:0]) : diff[63:0];
			neg_s5  <= diff[64];
			sat_s5  <= big_s4 || sum_s4[64] || (!diff[64] && diff[63]);
			if (sat_s5) begin
				level_s6.level_value <= cfg.inside_negative ? LEVEL_MAX : LEVEL_MIN;
			end else begin
				level_s6.level_value <= flip ? -$signed(mag_s5) : $signed(mag_s5);
			end
			level_s6.saturated <= sat_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[4:0], in_valid};
		end
	end

	assign out_valid = v_s[5];
	assign out_level = level_s6;

endmodule

### rtl/core/htl_chk.sv
// Port-level checker for the helix tube level value block, bound to the top level.
`timescale 1ns / 1ps

module htl_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input htl_pkg::level_t   out_data
);
	import htl_pkg::*;

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input backs up exactly when the result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not track output stall");

	// a clamped result sits at one of the range ends
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.level_value == LEVEL_MAX) || (out_data.level_value == LEVEL_MIN))
		else $error("saturated result not at a range end");

	// an unclamped magnitude never reaches the negative end
	a_noclamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.saturated |-> out_data.level_value != LEVEL_MIN)
		else $error("unsaturated result at the negative end");

endmodule

bind helix_tube_level_value htl_chk u_htl_chk (.*);

### tb/sv/tb_helix_tube_level_value.sv
// Self-checking testbench of the helix tube level value datapath.
`timescale 1ns / 1ps

module tb_helix_tube_level_value;
	import htl_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	point_t      in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	level_t      out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_HELIX_RADIUS;
	logic [31:0] cfg_data = '0;

	helix_tube_level_value dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int LATENCY = 135;
	localparam longint unsigned INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

	// atan(2^-i) in Q.28 radians for the rotation stages
	localparam longint ROT_ANGLE [0:23] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32
	};

	// shadow of the register file
	longint unsigned helix_r = 65536;
	longint unsigned helix_p = 65536;
	longint unsigned tube_r  = 16384;
	bit              keep_sign = 1'b1;

	level_t level_q [$];
	int     err_count = 0;
	bit     quiet = 1'b0;
	int     hold_cycles = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("tb_helix_tube_level_value NOT OK");
		$finish;
	end

	function automatic longint polar_angle(longint px, longint py);
		longint x, y, t, dx, dy, ang;
		x = px <<< 28;
		y = py <<< 28;
		ang = 0;
		if (px == 0 && py == 0)
			return 0;
		// fold the left half-plane onto the right one
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; ang = PI_HALF_Q;
			end else begin
				x = -y; y = t; ang = -longint'(PI_HALF_Q);
			end
		end
		for (int i = 0; i < 24; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; ang += ROT_ANGLE[i];
			end else begin
				x -= dy; y += dx; ang -= ROT_ANGLE[i];
			end
		end
		return ang;
	endfunction

	function automatic longint unsigned nearest_root(longint unsigned s);
		longint unsigned r, b, v;
		r = 0;
		b = 64'd1 << 62;
		v = s;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		if (s - r * r > r)
			r++;
		return r;
	endfunction

	function automatic level_t predict_level(point_t p);
		longint px, py, pz, w, len, r0, dxy, sval;
		longint unsigned dz, dzf, rho, dxy2, dz2, sum, r2, mag, adxy;
		bit sat, neg;
		level_t res;
		px = p.point_x; py = p.point_y; pz = p.point_z;
		sat = 0; neg = 0; mag = 0;
		w = (pz <<< 28) - longint'(helix_p) * polar_angle(px, py);
		len = longint'(helix_p) * longint'(TWO_PI_Q);
		if (len == 0)
			dz = (w < 0) ? -w : w;
		else begin
			r0 = w % len;
			if (r0 < 0) r0 += len;
			dz = (r0 < len - r0) ? r0 : len - r0;
		end
		dzf = (dz + (64'd1 << 27)) >> 28;
		rho = nearest_root(longint'(px * px) + longint'(py * py));
		dxy = longint'(rho) - longint'(helix_r);
		adxy = (dxy < 0) ? -dxy : dxy;
		dxy2 = adxy * adxy;
		r2 = tube_r * tube_r;
		if (dzf >= (64'd1 << 32))
			sat = 1;
		else begin
			dz2 = dzf * dzf;
			sum = dxy2 + dz2;
			if (sum < dxy2)
				sat = 1;
			else if (sum >= r2) begin
				mag = sum - r2;
				if (mag > INT64_TOP) sat = 1;
			end else begin
				mag = r2 - sum;
				neg = 1;
			end
		end
		if (sat)
			res.level_value = keep_sign ? LEVEL_MAX : LEVEL_MIN;
		else begin
			sval = neg ? -longint'(mag) : longint'(mag);
			if (!keep_sign) sval = -sval;
			res.level_value = sval;
		end
		res.saturated = sat;
		return res;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		$display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
	endtask

	// result side: check every transfer, draw stalls
	initial begin
		int stall_left;
		level_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (level_q.size() == 0)
					report("unexpected result", out_data.level_value, 0);
				else begin
					want = level_q.pop_front();
					if (out_data.level_value !== want.level_value)
						report("level_value", out_data.level_value, want.level_value);
					if (out_data.saturated !== want.saturated)
						report("saturated", out_data.saturated, want.saturated);
				end
				stall_left = quiet ? 0 : $urandom_range(0, 7);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic send_point(point_t p);
		int gap;
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (in_stall);
		level_q.push_back(predict_level(p));
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		end_burst();
		while (level_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_HELIX_RADIUS:    helix_r = val & 32'h7FFF_FFFF;
			CFG_HELIX_PITCH:     helix_p = val & 32'h7FFF_FFFF;
			CFG_TUBE_RADIUS:     tube_r = val & 32'h7FFF_FFFF;
			CFG_INSIDE_NEGATIVE: keep_sign = val[0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_shape(logic [31:0] r, logic [31:0] p, logic [31:0] t, bit k);
		write_reg(CFG_HELIX_RADIUS, r);
		write_reg(CFG_HELIX_PITCH, p);
		write_reg(CFG_TUBE_RADIUS, t);
		write_reg(CFG_INSIDE_NEGATIVE, {31'd0, k});
	endtask

	function automatic point_t mk(int x, int y, int z);
		point_t p;
		p.point_x = x; p.point_y = y; p.point_z = z;
		return p;
	endfunction

	// mostly points near the helix, some across the full range
	function automatic point_t random_point();
		int span;
		if ($urandom_range(0, 3) == 0)
			return mk($urandom, $urandom, $urandom);
		span = 1 << $urandom_range(12, 22);
		return mk($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
			$urandom_range(0, 8 * span) - 4 * span);
	endfunction

	task automatic test_directed();
		send_point(mk(0, 0, 0));
		send_point(mk(0, 0, 32'h7FFF_FFFF));
		send_point(mk(0, 0, 32'h8000_0000));
		send_point(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_point(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_point(mk(32'h8000_0000, 0, 0));
		send_point(mk(0, 32'h8000_0000, 0));
		send_point(mk(32'h8000_0000, 32'h7FFF_FFFF, 0));
		send_point(mk(32'h7FFF_FFFF, 32'h8000_0000, 0));
		send_point(mk(65536, 0, 0));
		send_point(mk(-65536, 0, 205887));
		send_point(mk(-65536, 1, 205887));
		send_point(mk(-65536, -1, -205887));
		send_point(mk(0, 65536, 102944));
		send_point(mk(0, -65536, -102944));
		send_point(mk(65536, 0, 205887));
		send_point(mk(70000, 3000, 411775));
		send_point(mk(-1, -1, -1));
		send_point(mk(1, 1, 1));
		send_point(mk(16384, 0, 0));
		drain();
	endtask

	task automatic test_settings();
		logic [31:0] r, p, t;
		for (int s = 0; s < 8; s++) begin
			case (s)
				0: set_shape(0, 0, 0, 1'b0);
				1: set_shape(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
				2: set_shape(32'h7FFF_FFFF, 1, 0, 1'b0);
				3: set_shape(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
				4: set_shape(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
				default: begin
					r = $urandom_range(0, 1 << 20);
					p = $urandom_range(1, 1 << 18);
					t = $urandom_range(0, r + 1);
					set_shape(r, p, t, 1'($urandom_range(0, 1)));
				end
			endcase
			for (int i = 0; i < 30; i++) send_point(random_point());
			drain();
		end
		set_shape(65536, 65536, 16384, 1'b1);
	endtask

	task automatic test_random();
		for (int i = 0; i < 150; i++) begin
			quiet = (i >= 60 && i < 110);
			send_point(random_point());
		end
		quiet = 0;
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 200; i++) send_point(random_point());
		end_burst();
		while (level_q.size() != 0) @(posedge clk);
		// sender waits for everything before resuming
		for (int i = 0; i < 20; i++) send_point(random_point());
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		test_random();
		test_backpressure();
		if (err_count == 0)
			$display("tb_helix_tube_level_value OK");
		else
			$display("tb_helix_tube_level_value NOT OK");
		$finish;
	end

endmodule
